### hw/rtl/u8sd_pkg.sv
package u8sd_pkg;

  localparam int unsigned UnitW    = 21;
  localparam int unsigned MaxUnits = 4;

  localparam logic [UnitW-1:0] ReplChar  = 21'h00FFFD;
  localparam logic [UnitW-1:0] MaxCp     = 21'h10FFFF;
  localparam logic [UnitW-1:0] SurrLo    = 21'h00D800;
  localparam logic [UnitW-1:0] SurrHi    = 21'h00DFFF;
  localparam logic [UnitW-1:0] BmpMax    = 21'h00FFFF;
  localparam logic [UnitW-1:0] SuppBase  = 21'h010000;
  localparam logic [15:0]      HiSurrBase = 16'hD800;
  localparam logic [15:0]      LoSurrBase = 16'hDC00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             last_of_run;
  } out_item_t;

  // results caused by one input item, in order
  typedef struct packed {
    logic [MaxUnits-1:0][UnitW-1:0] unit;
    logic [2:0]                     count;
  } res_list_t;

endpackage

### hw/rtl/u8sd_decode.sv
module u8sd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  u8sd_pkg::in_item_t  item,
  input  logic                utf16,
  output u8sd_pkg::res_list_t res
);

  logic [2:0]  exp_len, exp_len_next;
  logic [2:0]  coll, coll_next;
  logic [20:0] partial, partial_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= 3'd0;
      coll    <= 3'd0;
      partial <= 21'd0;
    end else if (load) begin
      exp_len <= exp_len_next;
      coll    <= coll_next;
      partial <= partial_next;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic        eos;
    logic        is_cont;
    logic [2:0]  lead_len;
    logic [20:0] lead_bits;
    logic        lead_multi;
    logic        lead_opens;
    logic [2:0]  lead_n;
    logic [20:0] lead_unit;
    logic [20:0] acc;
    logic [2:0]  coll1;
    logic        bad;
    logic [20:0] cp;
    logic [20:0] v;

    b   = item.data_byte;
    eos = item.end_of_stream;
    is_cont = (b[7:6] == 2'b10);

    // lead byte classification
    lead_len   = 3'd0;
    lead_bits  = 21'd0;
    lead_multi = 1'b0;
    lead_n     = 3'd1;
    lead_unit  = u8sd_pkg::ReplChar;
    if (b[7] == 1'b0) begin
      lead_unit = {13'd0, b};
    end else if (b[7:5] == 3'b110) begin
      lead_multi = 1'b1; lead_len = 3'd2; lead_bits = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      lead_multi = 1'b1; lead_len = 3'd3; lead_bits = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      lead_multi = 1'b1; lead_len = 3'd4; lead_bits = {18'd0, b[2:0]};
    end
    lead_opens = lead_multi && !eos;
    if (lead_opens) begin
      lead_n = 3'd0;
    end

    acc   = {partial[14:0], b[5:0]};
    coll1 = coll + 3'd1;

    bad = ((exp_len == 3'd2) && (acc < 21'h80)) ||
          ((exp_len == 3'd3) && (acc < 21'h800)) ||
          ((exp_len == 3'd4) && (acc < u8sd_pkg::SuppBase)) ||
          (acc > u8sd_pkg::MaxCp) ||
          ((acc >= u8sd_pkg::SurrLo) && (acc <= u8sd_pkg::SurrHi));
    cp = bad ? u8sd_pkg::ReplChar : acc;
    v  = cp - u8sd_pkg::SuppBase;

    exp_len_next = exp_len;
    coll_next    = coll;
    partial_next = partial;
    res.count    = 3'd0;
    for (int i = 0; i < u8sd_pkg::MaxUnits; i++) begin
      res.unit[i] = u8sd_pkg::ReplChar;
    end

    if (exp_len == 3'd0) begin
      res.unit[0] = lead_unit;
      res.count   = lead_n;
      if (lead_opens) begin
        exp_len_next = lead_len;
        coll_next    = 3'd1;
        partial_next = lead_bits;
      end
    end else if (is_cont) begin
      if (coll1 >= exp_len) begin
        if (utf16 && (cp > u8sd_pkg::BmpMax)) begin
          res.unit[0] = {5'd0, u8sd_pkg::HiSurrBase + {6'd0, v[19:10]}};
          res.unit[1] = {5'd0, u8sd_pkg::LoSurrBase + {6'd0, v[9:0]}};
          res.count   = 3'd2;
        end else begin
          res.unit[0] = cp;
          res.count   = 3'd1;
        end
        exp_len_next = 3'd0;
        coll_next    = 3'd0;
        partial_next = 21'd0;
      end else if (eos) begin
        // flush lead plus every continuation byte seen, this one included
        res.count    = coll1;
        exp_len_next = 3'd0;
        coll_next    = 3'd0;
        partial_next = 21'd0;
      end else begin
        coll_next    = coll1;
        partial_next = acc;
      end
    end else begin
      // broken sequence: one replacement per buffered byte, then rescan as lead
      for (int i = 0; i < u8sd_pkg::MaxUnits; i++) begin
        if (3'(i) >= coll) begin
          res.unit[i] = lead_unit;
        end
      end
      res.count    = coll + lead_n;
      exp_len_next = 3'd0;
      coll_next    = 3'd0;
      partial_next = 21'd0;
      if (lead_opens) begin
        exp_len_next = lead_len;
        coll_next    = 3'd1;
        partial_next = lead_bits;
      end
    end
  end

endmodule

### hw/rtl/u8sd_outbuf.sv
module u8sd_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  u8sd_pkg::res_list_t  res,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u8sd_pkg::out_item_t  out_data
);

  logic [u8sd_pkg::MaxUnits-1:0][u8sd_pkg::UnitW-1:0] units;
  logic [2:0] count;
  logic [1:0] ptr;
  logic       busy;
  logic       at_last;
  logic       take;

  assign at_last   = ({1'b0, ptr} == (count - 3'd1));
  assign take      = busy && out_ready;
  assign free      = !busy || (take && at_last);
  assign out_valid = busy;

  assign out_data.code_unit   = units[ptr];
  assign out_data.last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ptr  <= 2'd0;
    end else if (load) begin
      busy <= (res.count != 3'd0);
      ptr  <= 2'd0;
    end else if (take) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        ptr <= ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      units <= res.unit;
      count <= res.count;
    end
  end

endmodule

### hw/rtl/utf8_stream_decoder.sv
// UTF-8 byte stream to UTF-16 code units (cfg bit set, the reset value) or whole
// code points (cfg bit clear). Bytes pass an input register and the decoder into
// a registered result buffer, loaded once it is free. A byte is accepted every
// cycle while each byte yields at most one result and out_ready stays high; a
// byte that yields more (surrogate pairs, error flushes, up to 4) holds the result
// buffer while it drains one result per cycle as out_ready allows, and input
// stalls while a byte waits in the input register. Malformed input gives U+FFFD
// as described for the decoder; last_of_run marks the final result of each byte.
module utf8_stream_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  u8sd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output u8sd_pkg::out_item_t out_data
);

  logic                utf16;
  logic                held;
  u8sd_pkg::in_item_t  held_item;
  logic                free;
  logic                load;
  u8sd_pkg::res_list_t res;

  assign load     = held && free;
  assign in_ready = !held || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      utf16 <= 1'b1;
    end else if (cfg_we) begin
      utf16 <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_data;
    end
  end

  u8sd_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .item  (held_item),
    .utf16 (utf16),
    .res   (res)
  );

  u8sd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/u8sd_checker.sv
module u8sd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input u8sd_pkg::out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // input only backs up behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a run keeps going until its last result
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_of_run |=> out_valid)
    else $error("run ended without last_of_run");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.code_unit <= u8sd_pkg::MaxCp)
    else $error("code unit out of range");

endmodule

bind utf8_stream_decoder u8sd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/utf8_stream_decoder_test.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_test;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  u8sd_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  u8sd_pkg::out_item_t out_data;

  utf8_stream_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // decoder state as predicted
  bit          utf16_mode = 1'b1;
  logic [2:0]  seq_len = '0;
  logic [2:0]  seq_cnt = '0;
  logic [20:0] seq_bits = '0;

  u8sd_pkg::in_item_t  byte_backlog[$];
  u8sd_pkg::out_item_t units_due[$];
  u8sd_pkg::out_item_t step_units[$];

  int          errors = 0;
  bit          in_taken = 1'b0;
  bit          steady = 1'b0;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0]  pat_pos = '0;
  int          gap_left = 0;
  int          burst_left = 0;

  task automatic flag_unit(string what, u8sd_pkg::out_item_t got, u8sd_pkg::out_item_t want);
    $display("%0t mismatch, %s: got %06h/%0b want %06h/%0b", $time, what,
             got.code_unit, got.last_of_run, want.code_unit, want.last_of_run);
    errors++;
  endtask

  function automatic void queue_unit(logic [20:0] v);
    u8sd_pkg::out_item_t r;
    r.code_unit   = v;
    r.last_of_run = 1'b0;
    step_units.insert(step_units.size(), r);
  endfunction

  function automatic void drop_sequence();
    seq_len  = '0;
    seq_cnt  = '0;
    seq_bits = '0;
  endfunction

  function automatic void emit_code_point(logic [20:0] cp, logic [2:0] len);
    logic [20:0] v;
    if ((len == 3'd2 && cp < 21'h80) || (len == 3'd3 && cp < 21'h800) ||
        (len == 3'd4 && cp < u8sd_pkg::SuppBase) || cp > u8sd_pkg::MaxCp ||
        (cp >= u8sd_pkg::SurrLo && cp <= u8sd_pkg::SurrHi))
      cp = u8sd_pkg::ReplChar;
    if (utf16_mode && cp > u8sd_pkg::BmpMax) begin
      v = cp - u8sd_pkg::SuppBase;
      queue_unit({5'd0, u8sd_pkg::HiSurrBase} + {11'd0, v[19:10]});
      queue_unit({5'd0, u8sd_pkg::LoSurrBase} + {11'd0, v[9:0]});
    end else begin
      queue_unit(cp);
    end
  endfunction

  function automatic void take_lead(logic [7:0] b, logic eos);
    logic [2:0]  len;
    logic [20:0] bits;
    if (!b[7]) begin
      queue_unit({13'd0, b});
      return;
    end
    if (b[7:5] == 3'b110) begin
      len  = 3'd2;
      bits = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      len  = 3'd3;
      bits = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      len  = 3'd4;
      bits = {18'd0, b[2:0]};
    end else begin
      queue_unit(u8sd_pkg::ReplChar);
      return;
    end
    // a multibyte lead carrying the end mark can't be completed
    if (eos) begin
      queue_unit(u8sd_pkg::ReplChar);
      return;
    end
    seq_len  = len;
    seq_cnt  = 3'd1;
    seq_bits = bits;
  endfunction

  function automatic void decode_byte(u8sd_pkg::in_item_t it);
    u8sd_pkg::out_item_t r;
    int                  k;
    step_units.delete();
    if (seq_len == 0) begin
      take_lead(it.data_byte, it.end_of_stream);
    end else if (it.data_byte[7:6] == 2'b10) begin
      seq_bits = {seq_bits[14:0], it.data_byte[5:0]};
      seq_cnt++;
      if (seq_cnt >= seq_len) begin
        emit_code_point(seq_bits, seq_len);
        drop_sequence();
      end else if (it.end_of_stream) begin
        for (k = 0; k < seq_cnt; k++) queue_unit(u8sd_pkg::ReplChar);
        drop_sequence();
      end
    end else begin
      // broken sequence: flush what was buffered, then rescan this byte as a lead
      for (k = 0; k < seq_cnt; k++) queue_unit(u8sd_pkg::ReplChar);
      drop_sequence();
      take_lead(it.data_byte, it.end_of_stream);
    end
    for (k = 0; k < step_units.size(); k++) begin
      r = step_units[k];
      r.last_of_run = (k == step_units.size() - 1);
      units_due.insert(units_due.size(), r);
    end
  endfunction

  // driver: bursts of items with random gaps and receiver stalls that follow stall_pat, both off when steady
  always @(negedge clk) begin : drv
    bit give;
    give = 1'b0;
    if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (byte_backlog.size() != 0) begin
        give = 1'b1;
        in_data <= byte_backlog.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      in_valid <= give;
    end
    out_ready <= steady ? 1'b1 : stall_pat[pat_pos];
    pat_pos   <= pat_pos + 4'd1;
  end

  always @(posedge clk) begin : mon
    u8sd_pkg::out_item_t want;
    in_taken <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) decode_byte(in_data);
    if (!rst && out_valid && out_ready) begin
      if (units_due.size() == 0) begin
        flag_unit("result with nothing pending", out_data, '0);
      end else begin
        want = units_due.pop_front();
        if (out_data.code_unit !== want.code_unit) flag_unit("code_unit", out_data, want);
        if (out_data.last_of_run !== want.last_of_run) flag_unit("last_of_run", out_data, want);
      end
    end
  end

  function automatic void put_byte(logic [7:0] b, logic eos);
    u8sd_pkg::in_item_t it;
    it.data_byte     = b;
    it.end_of_stream = eos;
    byte_backlog.insert(byte_backlog.size(), it);
  endfunction

  // one stretch of stream: mostly well-formed sequences, some cut short, some noise
  function automatic void add_random_run();
    int         kind;
    int         len;
    int         keep;
    int         k;
    logic [7:0] lead;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 4);
    case (len)
      1: lead = 8'($urandom_range(0, 127));
      2: lead = 8'hC0 | 8'($urandom_range(0, 31));
      3: lead = 8'hE0 | 8'($urandom_range(0, 15));
      default: lead = 8'hF0 | 8'(($urandom_range(0, 5) == 0) ? $urandom_range(5, 7)
                                                              : $urandom_range(0, 4));
    endcase
    if (kind >= 8) begin
      put_byte(8'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    keep = (kind <= 5) ? len : $urandom_range(1, len);
    put_byte(lead, $urandom_range(0, 15) == 0);
    for (k = 1; k < keep; k++)
      put_byte(8'h80 | 8'($urandom_range(0, 63)), $urandom_range(0, 15) == 0);
    if (kind > 5) put_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endfunction

  task automatic write_mode(bit m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    utf16_mode = m;
  endtask

  // wait for the block to go idle; zero-result bytes may still be in the pipe
  task automatic drain();
    while (byte_backlog.size() != 0 || in_valid || units_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset mode (UTF-16)
    put_byte(8'h00, 0); put_byte(8'h7F, 1);
    put_byte(8'hC3, 0); put_byte(8'hA9, 0);
    put_byte(8'hE2, 0); put_byte(8'h82, 0); put_byte(8'hAC, 0);
    put_byte(8'hF0, 0); put_byte(8'h9F, 0); put_byte(8'h98, 0); put_byte(8'h80, 1);
    put_byte(8'h80, 0); put_byte(8'hFF, 0);
    put_byte(8'hC0, 0); put_byte(8'h80, 0);
    put_byte(8'hED, 0); put_byte(8'hA0, 0); put_byte(8'h80, 0);
    put_byte(8'hF4, 0); put_byte(8'h90, 0); put_byte(8'h80, 0); put_byte(8'h80, 0);
    put_byte(8'hE2, 0); put_byte(8'h82, 0); put_byte(8'h41, 0);
    put_byte(8'hF4, 0); put_byte(8'h8F, 0); put_byte(8'hBF, 1);
    put_byte(8'hC3, 1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_mode(phase[0] ? 1'b1 : 1'b0);
      steady    = (phase == 2);
      stall_pat = 16'(($urandom_range(0, 1) != 0) ? $urandom() : ($urandom() & $urandom()))
                  | 16'h1;
      while (byte_backlog.size() < 44) add_random_run();
      drain();
    end

    if (errors == 0) begin
      $display("[utf8_stream_decoder] OK");
    end else begin
      $display("[utf8_stream_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[utf8_stream_decoder] ERROR");
    $finish;
  end

endmodule

### sim.f
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_decode.sv
hw/rtl/u8sd_outbuf.sv
hw/rtl/utf8_stream_decoder.sv
hw/rtl/u8sd_checker.sv
tb/utf8_stream_decoder_test.sv
